@@ design/mtap_pkg.sv @@
`default_nettype none
package mtap_pkg;

  localparam int ADDR_W = 21;
  localparam int PAD_MAX = 5;
  localparam int PAD_LINES_W = 12;
  localparam int PAD_TYPES_W = 2 * PAD_MAX;
  localparam int CFG_DATA_W = PAD_TYPES_W;

  localparam int DEF_PAD_COUNT = 5;
  localparam int DEF_BACKUP_BYTES = 2048;

  // 1 KB pages: compare address bits above the page offset
  localparam int PAGE_LSB = 10;
  localparam logic [ADDR_W-1:0] JOY_PAGE = 21'h1ff000;
  localparam logic [ADDR_W-1:0] LOCK_PAGE = 21'h1ff800;
  localparam logic [ADDR_W-1:0] BRAM_BASE = 21'h1ee000;

  localparam logic [3:0] LOCK_RD_NIB = 4'h3;
  localparam logic [3:0] UNLOCK_WR_NIB = 4'h7;

  localparam logic MODE_READ = 1'b0;
  localparam logic MODE_WRITE = 1'b1;

  localparam logic REG_PAD_TYPES = 1'b0;
  localparam logic REG_REGION = 1'b1;

  localparam logic [1:0] TYPE_TWO_BUTTON = 2'd0;
  localparam logic [1:0] TYPE_SIX_TOGGLE = 2'd2;

  localparam logic [3:0] NIB_NO_PAD = 4'hf;

  typedef logic [PAD_MAX-1:0][PAD_LINES_W-1:0] pad_lines_t;

  typedef struct packed {
    logic       wr;
    logic [7:0] data;
  } joy_cmd_t;

endpackage
`default_nettype wire

@@ design/mtap_joy.sv @@
`default_nettype none
module mtap_joy
  import mtap_pkg::*;
#(
  parameter int PAD_COUNT = DEF_PAD_COUNT
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire joy_cmd_t               cmd,
  input  wire logic [PAD_TYPES_W-1:0] pad_types,
  input  wire logic                   region,
  input  wire pad_lines_t             pads,
  output logic [7:0]                  joy_byte
);

  logic [2:0] port_counter, port_counter_next;
  logic nibble_select;
  logic [PAD_COUNT-1:0] phase, phase_next;

  logic [3:0] nib;
  logic [PAD_LINES_W-1:0] sel_lines;
  logic [1:0] sel_kind;
  logic sel_phase;
  logic sel_hit;
  logic [PAD_LINES_W-1:0] v;

  always_comb begin
    sel_lines = '0;
    sel_kind = TYPE_TWO_BUTTON;
    sel_phase = 1'b0;
    sel_hit = 1'b0;
    for (int i = 0; i < PAD_COUNT; i++) begin
      if (port_counter == 3'(i)) begin
        sel_lines = pads[i];
        sel_kind = pad_types[2*i +: 2];
        sel_phase = phase[i];
        sel_hit = 1'b1;
      end
    end
    if (sel_kind == TYPE_TWO_BUTTON) begin
      v = {4'b0, sel_lines[7:0]};
    end else if (sel_phase) begin
      v = {8'b0, sel_lines[11:8]};
    end else begin
      v = sel_lines;
    end
    if (nibble_select) begin
      v = v >> 4;
    end
    nib = sel_hit ? v[3:0] : NIB_NO_PAD;
    joy_byte = {1'b1, region, 2'b11, nib};
  end

  always_comb begin
    port_counter_next = port_counter;
    phase_next = phase;
    if (!nibble_select && cmd.data[0]) begin
      port_counter_next = port_counter + 3'd1;
    end
    if (cmd.data[1]) begin
      port_counter_next = '0;
      for (int i = 0; i < PAD_COUNT; i++) begin
        if (pad_types[2*i +: 2] == TYPE_SIX_TOGGLE) begin
          phase_next[i] = ~phase[i];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      port_counter <= '0;
      nibble_select <= 1'b0;
      phase <= '0;
    end else if (cmd.wr) begin
      port_counter <= port_counter_next;
      nibble_select <= cmd.data[0];
      phase <= phase_next;
    end
  end

  // a clear bit always lands the counter on pad 0
  a_clear_zeroes: assert property (@(posedge clk) disable iff (rst)
    cmd.wr && cmd.data[1] |=> port_counter == '0)
    else $error("port counter not cleared");

  a_state_only_on_write: assert property (@(posedge clk) disable iff (rst)
    !cmd.wr |=> $stable(port_counter) && $stable(nibble_select) && $stable(phase))
    else $error("pad state changed without a write");

  a_select_follows_bit0: assert property (@(posedge clk) disable iff (rst)
    cmd.wr |=> nibble_select == $past(cmd.data[0]))
    else $error("nibble select wrong");

endmodule
`default_nettype wire

@@ design/mtap_bram.sv @@
`default_nettype none
module mtap_bram
  import mtap_pkg::*;
#(
  parameter int BACKUP_BYTES = DEF_BACKUP_BYTES,
  localparam int AW = $clog2(BACKUP_BYTES)
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          rd_en,
  input  wire logic          wr_en,
  input  wire logic [AW-1:0] addr,
  input  wire logic [7:0]    wdata,
  output logic [7:0]         rdata,
  output logic               busy
);

  localparam logic [AW-1:0] LAST = AW'(BACKUP_BYTES - 1);

  logic [7:0] mem [BACKUP_BYTES];
  logic clearing;
  logic [AW-1:0] clr_addr;

  assign busy = clearing;

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= clr_addr + AW'(1);
      if (clr_addr == LAST) begin
        clearing <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (clearing) begin
      mem[clr_addr] <= '0;
    end else if (wr_en) begin
      mem[addr] <= wdata;
    end
    if (rd_en) begin
      rdata <= mem[addr];
    end
  end

  a_clear_ends_at_last: assert property (@(posedge clk) disable iff (rst)
    $fell(clearing) |-> $past(clr_addr) == LAST)
    else $error("clearing pass ended early");

  a_no_access_while_clearing: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !rd_en && !wr_en)
    else $error("access during clearing pass");

  a_no_read_write_together: assert property (@(posedge clk) disable iff (rst)
    !(rd_en && wr_en))
    else $error("read and write in the same beat");

endmodule
`default_nettype wire

@@ design/gamepad_multitap_and_backup_ram_io.sv @@
`default_nettype none
// Channel  Signals                                        Dir  Beat
// in       in_valid/in_ready, mode, bus_address,          in   one bus access
//          write_byte, pad0_buttons..pad4_buttons
// out      out_valid/out_ready, read_byte, claimed        out  one reply per access
// cfg      cfg_write, cfg_index, cfg_data                 in   register write
//
// One access per cycle while in_ready is high; its reply appears in the output
// register in the next cycle. For backup RAM reads, the RAM's read data register
// feeds read_byte in place of the output register. After reset a clearing pass
// zeroes the backup RAM with in_ready low; config writes are taken meanwhile.
// Once the clearing pass is done, in_ready drops only while the output register
// holds a beat not taken.
module gamepad_multitap_and_backup_ram_io
  import mtap_pkg::*;
#(
  parameter int PAD_COUNT = DEF_PAD_COUNT,
  parameter int BACKUP_BYTES = DEF_BACKUP_BYTES
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire logic                   mode,
  input  wire logic [ADDR_W-1:0]      bus_address,
  input  wire logic [7:0]             write_byte,
  input  wire logic [PAD_LINES_W-1:0] pad0_buttons,
  input  wire logic [PAD_LINES_W-1:0] pad1_buttons,
  input  wire logic [PAD_LINES_W-1:0] pad2_buttons,
  input  wire logic [PAD_LINES_W-1:0] pad3_buttons,
  input  wire logic [PAD_LINES_W-1:0] pad4_buttons,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output logic [7:0]                  read_byte,
  output logic                        claimed,
  input  wire logic                   cfg_write,
  input  wire logic                   cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int AW = $clog2(BACKUP_BYTES);

  logic [PAD_TYPES_W-1:0] pad_types;
  logic region;
  logic locked;

  logic accept;
  logic is_write;
  logic in_joy, in_lock, in_bram;
  logic [ADDR_W:0] bram_off;
  logic bram_busy;
  logic [7:0] bram_q;
  logic [7:0] joy_byte;
  joy_cmd_t joy_cmd;
  pad_lines_t pads;

  logic [7:0] rd_q, rd_next;
  logic ram_sel_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      pad_types <= '0;
      region <= 1'b1;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_PAD_TYPES: pad_types <= cfg_data[PAD_TYPES_W-1:0];
        REG_REGION:    region <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign in_ready = !bram_busy && (!out_valid || out_ready);
  assign accept = in_valid && in_ready;
  assign is_write = (mode == MODE_WRITE);

  assign in_joy = bus_address[ADDR_W-1:PAGE_LSB] == JOY_PAGE[ADDR_W-1:PAGE_LSB];
  assign in_lock = bus_address[ADDR_W-1:PAGE_LSB] == LOCK_PAGE[ADDR_W-1:PAGE_LSB];
  assign bram_off = {1'b0, bus_address} - {1'b0, BRAM_BASE};
  assign in_bram = !in_joy && !in_lock && !bram_off[ADDR_W]
                   && (bram_off[ADDR_W-1:0] < ADDR_W'(BACKUP_BYTES));

  assign pads = {pad4_buttons, pad3_buttons, pad2_buttons, pad1_buttons, pad0_buttons};
  assign joy_cmd.wr = accept && in_joy && is_write;
  assign joy_cmd.data = write_byte;

  mtap_joy #(.PAD_COUNT(PAD_COUNT)) u_joy (
    .clk(clk),
    .rst(rst),
    .cmd(joy_cmd),
    .pad_types(pad_types),
    .region(region),
    .pads(pads),
    .joy_byte(joy_byte)
  );

  mtap_bram #(.BACKUP_BYTES(BACKUP_BYTES)) u_bram (
    .clk(clk),
    .rst(rst),
    .rd_en(accept && in_bram && !is_write),
    .wr_en(accept && in_bram && is_write && !locked),
    .addr(bram_off[AW-1:0]),
    .wdata(write_byte),
    .rdata(bram_q),
    .busy(bram_busy)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      locked <= 1'b1;
    end else if (accept && in_lock) begin
      if (is_write) begin
        if (bus_address[3:0] == UNLOCK_WR_NIB && write_byte[7]) begin
          locked <= 1'b0;
        end
      end else if (bus_address[3:0] == LOCK_RD_NIB) begin
        locked <= 1'b1;
      end
    end
  end

  assign rd_next = (in_joy && !is_write) ? joy_byte : 8'h00;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rd_q <= rd_next;
      claimed <= in_joy || in_lock || in_bram;
      ram_sel_q <= in_bram && !is_write;
    end
  end

  assign read_byte = ram_sel_q ? bram_q : rd_q;

  a_accept_gives_beat: assert property (@(posedge clk) disable iff (rst)
    accept |=> out_valid)
    else $error("accepted access produced no reply");

  a_unlock_needs_write: assert property (@(posedge clk) disable iff (rst)
    $fell(locked) |-> $past(accept && in_lock && is_write))
    else $error("backup RAM unlocked without a lock page write");

  a_unclaimed_reads_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !claimed |-> read_byte == 8'h00)
    else $error("unclaimed reply carries data");

endmodule
`default_nettype wire
